// ----- rtl/core/hlbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_pkg
// Shared constants, types and the sine table for the Hough line border
// endpoint pipeline.
// ----------------------------------------------------------------------------
package hlbe_pkg;

   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;

   localparam int RHO_W  = 11;
   localparam int ANG_W  = 8;
   localparam int X_W    = 10;
   localparam int Y_W    = 9;

   // trig values: signed Q2.16, magnitude at most 65536
   localparam int FRAC_W = 16;
   localparam int MAG_W  = 17;
   localparam int TRIG_W = MAG_W + 1;

   localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
   localparam int QUO_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int NUM_W   = TRIG_W + DIM_W + 1;
   localparam int REM_W   = QUO_W + MAG_W;
   localparam int LIM_W   = DIM_W + MAG_W;

   localparam int NUM_BORDERS = 4;
   localparam int BORDER_LEFT   = 0;
   localparam int BORDER_RIGHT  = 1;
   localparam int BORDER_TOP    = 2;
   localparam int BORDER_BOTTOM = 3;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam int TAB_MAX = 90;
   localparam int IDX_W   = 7;

   typedef logic [TAB_MAX:0][MAG_W-1:0] sin_tab_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             neg;
   } fold_type;

   typedef struct packed {
      logic              cand;
      logic [REM_W-1:0]  num_mag;
      logic [MAG_W-1:0]  den_mag;
   } border_type;

   typedef struct packed {
      logic             hit;
      logic [QUO_W-1:0] quo;
   } quot_type;

   // first quadrant sine, Taylor series in Q30 rounded to Q16
   function automatic sin_tab_type build_sin_table();
      sin_tab_type t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      for (int d = 0; d <= TAB_MAX; d++) begin
         x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         // terms divided by (2k)(2k+1) for k = 1..7, alternating sign
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd210;
         sum  = sum - term;
         sum  = (sum + 64'd8192) >> 14;
         t[d] = sum[MAG_W-1:0];
      end
      return t;
   endfunction

   localparam sin_tab_type SIN_TABLE = build_sin_table();

   // fold a degree in 0..359 onto the first quadrant
   function automatic fold_type fold_angle(input logic [ANG_W:0] d);
      fold_type f;
      f.neg = 1'b0;
      if (d <= 9'd90) begin
         f.idx = d[IDX_W-1:0];
      end else if (d <= 9'd180) begin
         f.idx = IDX_W'(9'd180 - d);
      end else if (d <= 9'd270) begin
         f.idx = IDX_W'(d - 9'd180);
         f.neg = 1'b1;
      end else begin
         f.idx = IDX_W'(9'd360 - d);
         f.neg = 1'b1;
      end
      return f;
   endfunction

endpackage

// ----- rtl/core/hlbe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_req_if / hlbe_rsp_if
// Valid/ready channels carrying one Hough line and one endpoint pair.
// ----------------------------------------------------------------------------
interface hlbe_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [hlbe_pkg::RHO_W-1:0] rho;
   logic [hlbe_pkg::ANG_W-1:0]        angle;
   modport source (output valid, rho, angle, input ready);
   modport sink   (input valid, rho, angle, output ready);
endinterface

interface hlbe_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hlbe_pkg::X_W-1:0]   first_x;
   logic [hlbe_pkg::Y_W-1:0]   first_y;
   logic [hlbe_pkg::X_W-1:0]   second_x;
   logic [hlbe_pkg::Y_W-1:0]   second_y;
   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

// ----- rtl/core/hlbe_trig.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_trig
// Stage 1: sine and cosine lookup by quadrant fold, rho carried along.
// ----------------------------------------------------------------------------
module hlbe_trig (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [hlbe_pkg::RHO_W-1:0]  rho,
   input  logic [hlbe_pkg::ANG_W-1:0]         angle,
   output hlbe_pkg::trig_type                 trig,
   output logic signed [hlbe_pkg::RHO_W-1:0]  rho_out
);

   hlbe_pkg::fold_type sin_fold;
   hlbe_pkg::fold_type cos_fold;
   logic [hlbe_pkg::MAG_W-1:0] sin_mag;
   logic [hlbe_pkg::MAG_W-1:0] cos_mag;
   hlbe_pkg::trig_type trig_in, trig_ff;
   logic signed [hlbe_pkg::RHO_W-1:0] rho_ff;

   always_comb begin
      sin_fold = hlbe_pkg::fold_angle({1'b0, angle});
      cos_fold = hlbe_pkg::fold_angle({1'b0, angle} + 9'd90);
      sin_mag  = hlbe_pkg::SIN_TABLE[sin_fold.idx];
      cos_mag  = hlbe_pkg::SIN_TABLE[cos_fold.idx];
      trig_in.sin_val = sin_fold.neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      trig_in.cos_val = cos_fold.neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
         rho_ff  <= rho;
      end
   end

   assign trig    = trig_ff;
   assign rho_out = rho_ff;

endmodule

// ----- rtl/core/hlbe_numer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_numer
// Stages 2 and 3: border numerators, then sign test, magnitudes and the
// range check that bounds each quotient below its border size.
// ----------------------------------------------------------------------------
module hlbe_numer (
   input  logic                               clock,
   input  logic                               en,
   input  hlbe_pkg::trig_type                 trig,
   input  logic signed [hlbe_pkg::RHO_W-1:0]  rho,
   output hlbe_pkg::border_type               border [hlbe_pkg::NUM_BORDERS]
);

   localparam logic [hlbe_pkg::DIM_W-1:0] KX = hlbe_pkg::DIM_W'(hlbe_pkg::IMAGE_WIDTH - 1);
   localparam logic [hlbe_pkg::DIM_W-1:0] KY = hlbe_pkg::DIM_W'(hlbe_pkg::IMAGE_HEIGHT - 1);
   localparam logic [hlbe_pkg::DIM_W-1:0] SZ_W = hlbe_pkg::DIM_W'(hlbe_pkg::IMAGE_WIDTH);
   localparam logic [hlbe_pkg::DIM_W-1:0] SZ_H = hlbe_pkg::DIM_W'(hlbe_pkg::IMAGE_HEIGHT);

   logic signed [hlbe_pkg::NUM_W-1:0] r_full;
   logic signed [hlbe_pkg::NUM_W-1:0] num_in [hlbe_pkg::NUM_BORDERS];
   logic signed [hlbe_pkg::NUM_W-1:0] num_ff [hlbe_pkg::NUM_BORDERS];
   hlbe_pkg::trig_type trig_ff;
   hlbe_pkg::border_type border_in [hlbe_pkg::NUM_BORDERS];
   hlbe_pkg::border_type border_ff [hlbe_pkg::NUM_BORDERS];

   always_comb begin
      r_full = hlbe_pkg::NUM_W'(rho) <<< hlbe_pkg::FRAC_W;
      num_in[hlbe_pkg::BORDER_LEFT]   = r_full;
      num_in[hlbe_pkg::BORDER_RIGHT]  = r_full - trig.cos_val * $signed({1'b0, KX});
      num_in[hlbe_pkg::BORDER_TOP]    = r_full;
      num_in[hlbe_pkg::BORDER_BOTTOM] = r_full - trig.sin_val * $signed({1'b0, KY});
   end

   always_comb begin
      logic signed [hlbe_pkg::TRIG_W-1:0] den;
      logic [hlbe_pkg::NUM_W-1:0]         an;
      logic [hlbe_pkg::MAG_W-1:0]         ad;
      logic [hlbe_pkg::LIM_W-1:0]         lim;
      logic                               sign_ok;
      for (int b = 0; b < hlbe_pkg::NUM_BORDERS; b++) begin
         den = (b < 2) ? trig_ff.sin_val : trig_ff.cos_val;
         an  = num_ff[b][hlbe_pkg::NUM_W-1] ? hlbe_pkg::NUM_W'(-num_ff[b])
                                            : hlbe_pkg::NUM_W'(num_ff[b]);
         ad  = den[hlbe_pkg::TRIG_W-1] ? hlbe_pkg::MAG_W'(-den) : hlbe_pkg::MAG_W'(den);
         lim = ((b < 2) ? SZ_H : SZ_W) * ad;
         sign_ok = (num_ff[b] == '0) || (num_ff[b][hlbe_pkg::NUM_W-1] == den[hlbe_pkg::TRIG_W-1]);
         border_in[b].cand    = (den != '0) && sign_ok && (an < hlbe_pkg::NUM_W'(lim));
         border_in[b].num_mag = an[hlbe_pkg::REM_W-1:0];
         border_in[b].den_mag = ad;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff   <= trig;
         num_ff    <= num_in;
         border_ff <= border_in;
      end
   end

   assign border = border_ff;

endmodule

// ----- rtl/core/hlbe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_div
// Pipelined restoring divider, one quotient bit per stage. The numerator is
// known to be below size times the divisor, so the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module hlbe_div (
   input  logic                 clock,
   input  logic                 en,
   input  hlbe_pkg::border_type border,
   output hlbe_pkg::quot_type   result
);

   localparam int QW = hlbe_pkg::QUO_W;
   localparam int RW = hlbe_pkg::REM_W;

   logic [RW-1:0]             rem_ff [QW];
   logic [hlbe_pkg::MAG_W-1:0] den_ff [QW];
   logic [QW-1:0]             quo_ff [QW];
   logic                      hit_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      localparam int BIT = QW - 1 - g;
      logic [RW-1:0]              rem_prev;
      logic [hlbe_pkg::MAG_W-1:0] den_prev;
      logic [QW-1:0]              quo_prev;
      logic                       hit_prev;
      logic [RW-1:0]              shifted;
      logic                       take;

      if (g == 0) begin : g_first
         assign rem_prev = border.num_mag;
         assign den_prev = border.den_mag;
         assign quo_prev = '0;
         assign hit_prev = border.cand;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign den_prev = den_ff[g-1];
         assign quo_prev = quo_ff[g-1];
         assign hit_prev = hit_ff[g-1];
      end

      assign shifted = RW'(den_prev) << BIT;
      assign take    = rem_prev >= shifted;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= take ? rem_prev - shifted : rem_prev;
            den_ff[g] <= den_prev;
            quo_ff[g] <= quo_prev | (take ? QW'(1) << BIT : '0);
            hit_ff[g] <= hit_prev;
         end
      end
   end

   assign result.hit = hit_ff[QW-1];
   assign result.quo = quo_ff[QW-1];

endmodule

// ----- rtl/core/hough_line_border_endpoints.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_line_border_endpoints
// Clips a Hough line (rho, angle) to the image and returns the first two
// border intersections in the order left, right, top, bottom.
// ----------------------------------------------------------------------------
// One line is taken every cycle while the result channel is not stalled.
// Its endpoint pair passes through one stage of sine/cosine lookup, two
// stages of numerator and range check, one stage per quotient bit in four
// parallel restoring dividers, and the output register. A stall on the result
// channel holds the whole pipeline; ready on the input channel follows it.
// Lines with fewer than two border hits give an all-zero pair.
module hough_line_border_endpoints (
   input  logic       clock,
   input  logic       reset,
   hlbe_req_if.sink   req,
   hlbe_rsp_if.source rsp
);

   localparam int LAT = 3 + hlbe_pkg::QUO_W;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic rsp_valid_ff;

   hlbe_pkg::trig_type trig;
   logic signed [hlbe_pkg::RHO_W-1:0] rho_s1;
   hlbe_pkg::border_type border [hlbe_pkg::NUM_BORDERS];
   hlbe_pkg::quot_type   quot   [hlbe_pkg::NUM_BORDERS];

   logic [hlbe_pkg::X_W-1:0] fx_in, sx_in, fx_ff, sx_ff;
   logic [hlbe_pkg::Y_W-1:0] fy_in, sy_in, fy_ff, sy_ff;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   hlbe_trig u_trig (
      .clock   (clock),
      .en      (en),
      .rho     (req.rho),
      .angle   (req.angle),
      .trig    (trig),
      .rho_out (rho_s1)
   );

   hlbe_numer u_numer (
      .clock  (clock),
      .en     (en),
      .trig   (trig),
      .rho    (rho_s1),
      .border (border)
   );

   for (genvar b = 0; b < hlbe_pkg::NUM_BORDERS; b++) begin : g_div
      hlbe_div u_div (
         .clock  (clock),
         .en     (en),
         .border (border[b]),
         .result (quot[b])
      );
   end

   // pick the first two hits in border order
   always_comb begin
      logic [hlbe_pkg::X_W-1:0] px [hlbe_pkg::NUM_BORDERS];
      logic [hlbe_pkg::Y_W-1:0] py [hlbe_pkg::NUM_BORDERS];
      logic [1:0] cnt;
      px[hlbe_pkg::BORDER_LEFT]   = '0;
      py[hlbe_pkg::BORDER_LEFT]   = hlbe_pkg::Y_W'(quot[hlbe_pkg::BORDER_LEFT].quo);
      px[hlbe_pkg::BORDER_RIGHT]  = hlbe_pkg::X_W'(hlbe_pkg::IMAGE_WIDTH - 1);
      py[hlbe_pkg::BORDER_RIGHT]  = hlbe_pkg::Y_W'(quot[hlbe_pkg::BORDER_RIGHT].quo);
      px[hlbe_pkg::BORDER_TOP]    = hlbe_pkg::X_W'(quot[hlbe_pkg::BORDER_TOP].quo);
      py[hlbe_pkg::BORDER_TOP]    = '0;
      px[hlbe_pkg::BORDER_BOTTOM] = hlbe_pkg::X_W'(quot[hlbe_pkg::BORDER_BOTTOM].quo);
      py[hlbe_pkg::BORDER_BOTTOM] = hlbe_pkg::Y_W'(hlbe_pkg::IMAGE_HEIGHT - 1);
      cnt   = '0;
      fx_in = '0;
      fy_in = '0;
      sx_in = '0;
      sy_in = '0;
      for (int b = 0; b < hlbe_pkg::NUM_BORDERS; b++) begin
         if (quot[b].hit && cnt == 2'd0) begin
            fx_in = px[b];
            fy_in = py[b];
            cnt   = 2'd1;
         end else if (quot[b].hit && cnt == 2'd1) begin
            sx_in = px[b];
            sy_in = py[b];
            cnt   = 2'd2;
         end
      end
      if (cnt != 2'd2) begin
         fx_in = '0;
         fy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req.valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.first_x  = fx_ff;
   assign rsp.first_y  = fy_ff;
   assign rsp.second_x = sx_ff;
   assign rsp.second_y = sy_ff;

endmodule

// ----- rtl/core/hlbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlbe_checker
// Port-level checks for the border endpoint block, bound to the top level.
// ----------------------------------------------------------------------------
module hlbe_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hlbe_pkg::X_W-1:0]   first_x,
   input logic [hlbe_pkg::Y_W-1:0]   first_y,
   input logic [hlbe_pkg::X_W-1:0]   second_x,
   input logic [hlbe_pkg::Y_W-1:0]   second_y
);

   localparam bit X_FITS = hlbe_pkg::IMAGE_WIDTH <= (1 << hlbe_pkg::X_W);
   localparam bit Y_FITS = hlbe_pkg::IMAGE_HEIGHT <= (1 << hlbe_pkg::Y_W);

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_x) && $stable(first_y)
         && $stable(second_x) && $stable(second_y))
      else $error("result changed while stalled");

   // input side moves exactly when the output register can advance
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready out of step with output stall");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!X_FITS || (first_x < hlbe_pkg::IMAGE_WIDTH
         && second_x < hlbe_pkg::IMAGE_WIDTH))
         && (!Y_FITS || (first_y < hlbe_pkg::IMAGE_HEIGHT
         && second_y < hlbe_pkg::IMAGE_HEIGHT)))
      else $error("endpoint outside image");

endmodule

bind hough_line_border_endpoints hlbe_checker u_hlbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .first_x   (rsp.first_x),
   .first_y   (rsp.first_y),
   .second_x  (rsp.second_x),
   .second_y  (rsp.second_y)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives Hough lines (rho, angle) into the border endpoint pipeline and checks
// each endpoint pair against a behavioral model built from the sine table math.
// ----------------------------------------------------------------------------

typedef struct {
   logic [hlbe_pkg::X_W-1:0] fx;
   logic [hlbe_pkg::Y_W-1:0] fy;
   logic [hlbe_pkg::X_W-1:0] sx;
   logic [hlbe_pkg::Y_W-1:0] sy;
} endpoint_pair_type;

class endpoint_scoreboard;
   endpoint_pair_type pending[$];
   int    mismatches;
   int    lines_seen;
   int    pairs_checked;
   int    clipped_lines;

   function new();
      mismatches    = 0;
      lines_seen    = 0;
      pairs_checked = 0;
      clipped_lines = 0;
   endfunction

   // first quadrant sine in Q16 via Q30 taylor series
   function longint quad_sine(int unsigned d);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned acc;
      x    = (longint'(d) * 64'd3373259426 + 90) / 180;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      return longint'((acc + 8192) >> 14);
   endfunction

   function longint sine_q16(int unsigned d);
      if (d <= 90) return quad_sine(d);
      if (d <= 180) return quad_sine(180 - d);
      if (d <= 270) return -quad_sine(d - 180);
      return -quad_sine(360 - d);
   endfunction

   function bit border_cross(longint num, longint den, longint size, output longint coord);
      longint an;
      longint ad;
      coord = 0;
      if (num != 0 && ((num < 0) != (den < 0))) return 0;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      if (an / ad >= size) return 0;
      coord = an / ad;
      return 1;
   endfunction

   function void note_line(logic signed [hlbe_pkg::RHO_W-1:0] rho,
                           logic [hlbe_pkg::ANG_W-1:0] angle);
      longint s;
      longint c;
      longint r;
      longint v;
      longint px[4];
      longint py[4];
      longint w;
      longint h;
      int     n;
      endpoint_pair_type p;
      w = hlbe_pkg::IMAGE_WIDTH;
      h = hlbe_pkg::IMAGE_HEIGHT;
      s = sine_q16(angle);
      c = sine_q16(int'(angle) + 90);
      r = longint'(rho) * 65536;
      n = 0;
      if (s != 0) begin
         if (border_cross(r, s, h, v)) begin px[n] = 0; py[n] = v; n++; end
         if (border_cross(r - (w - 1) * c, s, h, v)) begin
            px[n] = w - 1; py[n] = v; n++;
         end
      end
      if (c != 0) begin
         if (n < 4 && border_cross(r, c, w, v)) begin px[n] = v; py[n] = 0; n++; end
         if (n < 4 && border_cross(r - (h - 1) * s, c, w, v)) begin
            px[n] = v; py[n] = h - 1; n++;
         end
      end
      if (n >= 2) begin
         p.fx = px[0][hlbe_pkg::X_W-1:0];
         p.fy = py[0][hlbe_pkg::Y_W-1:0];
         p.sx = px[1][hlbe_pkg::X_W-1:0];
         p.sy = py[1][hlbe_pkg::Y_W-1:0];
         clipped_lines++;
      end else begin
         p.fx = '0; p.fy = '0; p.sx = '0; p.sy = '0;
      end
      lines_seen++;
      pending.push_back(p);
   endfunction

   function void check_pair(endpoint_pair_type got);
      endpoint_pair_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected endpoint pair %0d,%0d %0d,%0d",
                     got.fx, got.fy, got.sx, got.sy);
         return;
      end
      want = pending.pop_front();
      pairs_checked++;
      if (got.fx !== want.fx || got.fy !== want.fy ||
          got.sx !== want.sx || got.sy !== want.sy) begin
         mismatches++;
         if (mismatches <= 10)
            $display("pair %0d: expected %0d,%0d %0d,%0d got %0d,%0d %0d,%0d",
                     pairs_checked, want.fx, want.fy, want.sx, want.sy,
                     got.fx, got.fy, got.sx, got.sy);
      end
   endfunction
endclass

module tb_top;

   localparam int LATENCY   = hlbe_pkg::QUO_W + 4;
   localparam int CYCLE_CAP = 400000;
   localparam int DIRECTED_ANGLES[10] = '{0, 1, 45, 89, 90, 91, 135, 179, 180, 255};
   localparam int DIRECTED_RHOS[6]    = '{0, 1, -1, 400, -800, 800};

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   cycle_count = 0;

   hlbe_req_if req ();
   hlbe_rsp_if rsp ();

   endpoint_scoreboard board;

   hough_line_border_endpoints dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   // receiver: random stalls, checks on each transfer
   always @(posedge clock) begin
      endpoint_pair_type got;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.fx = rsp.first_x;
            got.fy = rsp.first_y;
            got.sx = rsp.second_x;
            got.sy = rsp.second_y;
            board.check_pair(got);
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one line per call; holds valid until the transfer
   task automatic send_line(logic signed [hlbe_pkg::RHO_W-1:0] rho,
                            logic [hlbe_pkg::ANG_W-1:0] angle);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.rho   <= rho;
      req.angle <= angle;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_line(rho, angle);
   endtask

   task automatic random_lines(int count);
      logic signed [hlbe_pkg::RHO_W-1:0] rho;
      logic [hlbe_pkg::ANG_W-1:0]        angle;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: rho = hlbe_pkg::RHO_W'($urandom);
            1: rho = hlbe_pkg::RHO_W'(int'($urandom_range(20)) - 10);
            default: rho = hlbe_pkg::RHO_W'(int'($urandom_range(1600)) - 800);
         endcase
         if ($urandom_range(19) == 0) angle = hlbe_pkg::ANG_W'($urandom);
         else angle = hlbe_pkg::ANG_W'($urandom_range(179));
         send_line(rho, angle);
      end
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.rho        = '0;
      req.angle      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edges of the fields, axis-aligned lines and corner hits
      foreach (DIRECTED_ANGLES[a])
         send_line(hlbe_pkg::RHO_W'(DIRECTED_RHOS[a % 6]),
                   hlbe_pkg::ANG_W'(DIRECTED_ANGLES[a]));
      send_line(hlbe_pkg::RHO_W'(639), 8'd0);
      send_line(hlbe_pkg::RHO_W'(640), 8'd0);
      send_line(hlbe_pkg::RHO_W'(479), 8'd90);
      send_line(hlbe_pkg::RHO_W'(480), 8'd90);
      send_line(hlbe_pkg::RHO_W'(-1024), 8'd135);
      send_line(hlbe_pkg::RHO_W'(1023), 8'd45);
      send_line(hlbe_pkg::RHO_W'(0), 8'd135);
      send_line(hlbe_pkg::RHO_W'(-400), 8'd120);

      send_idle_pct = 10; recv_stall_pct = 46;
      random_lines(500);
      send_idle_pct = 46; recv_stall_pct = 10;
      random_lines(500);
      send_idle_pct = 0; recv_stall_pct = 0;
      random_lines(500);
      req.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("covered %0d lines, %0d endpoint pairs checked, %0d clipped to the image",
               board.lines_seen, board.pairs_checked, board.clipped_lines);
      $display("mismatches: %0d", board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
